// File: src/fsrg_pkg.sv
// ----------------------------------------------------------------------------
// fsrg_pkg
// Shared constants, operation codes and controller/datapath interface types
// for the filled shape raster grid.
// ----------------------------------------------------------------------------
package fsrg_pkg;

    localparam int ROW_W           = 64;
    localparam int COL_W           = 6;
    localparam int COORD_W         = 10;
    localparam int OP_W            = 3;
    localparam int EXT_W           = 6;
    localparam int RROW_W          = 4;
    localparam int CNT_W           = 7;
    localparam int DEF_GRID_WIDTH  = 64;
    localparam int DEF_GRID_HEIGHT = 16;

    localparam logic [OP_W-1:0] OP_CLEAR    = 3'd0;
    localparam logic [OP_W-1:0] OP_CIRCLE   = 3'd1;
    localparam logic [OP_W-1:0] OP_SQUARE   = 3'd2;
    localparam logic [OP_W-1:0] OP_TRIANGLE = 3'd3;
    localparam logic [OP_W-1:0] OP_READ     = 3'd4;

    typedef struct packed {
        logic load;
        logic clear;
        logic adj_step;
        logic rd_row;
        logic wr_row;
        logic next_row;
        logic capture;
    } fsrg_cmd_t;

    typedef struct packed {
        logic op_clear;
        logic op_draw;
        logic op_circle;
        logic op_read;
        logic count_zero;
        logic adjust;
        logic in_grid;
        logic last_row;
        logic out_free;
    } fsrg_sts_t;

endpackage

// File: src/fsrg_ram.sv
// ----------------------------------------------------------------------------
// fsrg_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module fsrg_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: src/fsrg_ctrl.sv
// ----------------------------------------------------------------------------
// fsrg_ctrl
// Command sequencer: decodes a word, walks the rows of a shape with one
// read-modify-write per on-grid row; read results go to the output register.
// ----------------------------------------------------------------------------
module fsrg_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  fsrg_pkg::fsrg_sts_t sts,
    output fsrg_pkg::fsrg_cmd_t cmd
);
    import fsrg_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE     = 6'b000001,
        ST_DISPATCH = 6'b000010,
        ST_ADJ      = 6'b000100,
        ST_ROW      = 6'b001000,
        ST_WR       = 6'b010000,
        ST_RESP     = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                if (sts.op_clear) begin
                    cmd.clear  = 1'b1;
                    state_next = ST_IDLE;
                end else if (sts.op_read) begin
                    cmd.rd_row = 1'b1;
                    state_next = ST_RESP;
                end else if (sts.op_draw && !sts.count_zero) begin
                    state_next = sts.op_circle ? ST_ADJ : ST_ROW;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_ADJ: begin
                if (sts.adjust) begin
                    cmd.adj_step = 1'b1;
                end else begin
                    state_next = ST_ROW;
                end
            end
            ST_ROW: begin
                if (sts.in_grid) begin
                    cmd.rd_row = 1'b1;
                    state_next = ST_WR;
                end else if (sts.last_row) begin
                    state_next = ST_IDLE;
                end else begin
                    cmd.next_row = 1'b1;
                    state_next   = sts.op_circle ? ST_ADJ : ST_ROW;
                end
            end
            ST_WR: begin
                cmd.wr_row = 1'b1;
                if (sts.last_row) begin
                    state_next = ST_IDLE;
                end else begin
                    cmd.next_row = 1'b1;
                    state_next   = sts.op_circle ? ST_ADJ : ST_ROW;
                end
            end
            ST_RESP: begin
                if (sts.out_free) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: src/fsrg_datapath.sv
// ----------------------------------------------------------------------------
// fsrg_datapath
// Shape registers, row walker, circle half-width tracker, span mask builder,
// row store with per-row valid bits, and the output register.
// ----------------------------------------------------------------------------
module fsrg_datapath #(
    parameter int GRID_WIDTH  = fsrg_pkg::DEF_GRID_WIDTH,
    parameter int GRID_HEIGHT = fsrg_pkg::DEF_GRID_HEIGHT
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  fsrg_pkg::fsrg_cmd_t               cmd,
    output fsrg_pkg::fsrg_sts_t               sts,
    input  logic [fsrg_pkg::OP_W-1:0]         s_operation,
    input  logic signed [7:0]                 s_pos_x,
    input  logic signed [7:0]                 s_pos_y,
    input  logic [fsrg_pkg::EXT_W-1:0]        s_extent,
    input  logic [fsrg_pkg::RROW_W-1:0]       s_read_row,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [fsrg_pkg::ROW_W-1:0]        m_row_bits,
    output logic [fsrg_pkg::RROW_W-1:0]       m_row_number
);
    import fsrg_pkg::*;

    localparam int ROW_AW = (GRID_HEIGHT > 1) ? $clog2(GRID_HEIGHT) : 1;
    localparam logic signed [COORD_W-1:0] HEIGHT_C = COORD_W'(GRID_HEIGHT);
    localparam logic signed [COORD_W-1:0] XMAX_C   = COORD_W'(GRID_WIDTH - 1);
    localparam logic [COL_W-1:0]          XMAX_COL = COL_W'(GRID_WIDTH - 1);
    localparam logic [COL_W-1:0]          TOP_COL  = COL_W'(ROW_W - 1);

    logic [OP_W-1:0]                op_reg;
    logic signed [COORD_W-1:0]      bx_reg;
    logic signed [COORD_W-1:0]      by_reg;
    logic [EXT_W-1:0]               ext_reg;
    logic [CNT_W-1:0]               cnt_reg;
    logic [CNT_W-1:0]               k_reg;
    logic [EXT_W-1:0]               w_reg;
    logic [2*EXT_W-1:0]             rsq_reg;
    logic [GRID_HEIGHT-1:0]         valid_reg;
    logic                           m_valid_reg;
    logic [ROW_W-1:0]               row_bits_reg;
    logic [RROW_W-1:0]              row_number_reg;

    logic signed [COORD_W-1:0]      px_s;
    logic signed [COORD_W-1:0]      py_s;
    logic signed [COORD_W-1:0]      ext_in_s;
    logic signed [7:0]              dy;
    logic                           dy_le0;
    logic [EXT_W-1:0]               dy_abs;
    logic [2*EXT_W-1:0]             dy_sq;
    logic [EXT_W:0]                 w_op;
    logic [2*EXT_W:0]               w_sq;
    logic [2*EXT_W+1:0]             dist_sum;
    logic                           grow;
    logic                           shrink;
    logic signed [COORD_W-1:0]      w_s;
    logic signed [COORD_W-1:0]      k_s;
    logic signed [COORD_W-1:0]      ext_s;
    logic signed [COORD_W-1:0]      cur_y;
    logic                           in_grid;
    logic [ROW_AW-1:0]              row_addr;
    logic signed [COORD_W-1:0]      span_lo;
    logic signed [COORD_W-1:0]      span_hi;
    logic                           span_empty;
    logic [COL_W-1:0]               lo_col;
    logic [COL_W-1:0]               hi_col;
    logic [ROW_W-1:0]               span_mask;
    logic                           row_valid;
    logic [ROW_W-1:0]               ram_rd_data;
    logic [ROW_W-1:0]               old_row;

    // input decode
    assign px_s     = {{(COORD_W-8){s_pos_x[7]}}, s_pos_x};
    assign py_s     = {{(COORD_W-8){s_pos_y[7]}}, s_pos_y};
    assign ext_in_s = {{(COORD_W-EXT_W){1'b0}}, s_extent};

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg  <= s_operation;
            bx_reg  <= px_s;
            ext_reg <= s_extent;
            k_reg   <= '0;
            w_reg   <= '0;
            rsq_reg <= s_extent * s_extent;
            case (s_operation)
                OP_CIRCLE: begin
                    by_reg  <= py_s - ext_in_s;
                    cnt_reg <= {s_extent, 1'b1};
                end
                OP_READ: begin
                    by_reg  <= {{(COORD_W-RROW_W){1'b0}}, s_read_row};
                    cnt_reg <= {1'b0, s_extent};
                end
                default: begin
                    by_reg  <= py_s;
                    cnt_reg <= {1'b0, s_extent};
                end
            endcase
        end else begin
            if (cmd.next_row) begin
                k_reg <= k_reg + 1'b1;
            end
            if (cmd.adj_step) begin
                w_reg <= grow ? w_reg + 1'b1 : w_reg - 1'b1;
            end
        end
        if (cmd.capture) begin
            row_bits_reg   <= row_valid ? ram_rd_data : '0;
            row_number_reg <= cur_y[RROW_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.clear) begin
                valid_reg <= '0;
            end else if (cmd.wr_row) begin
                valid_reg[row_addr] <= 1'b1;
            end
            if (cmd.capture) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // circle half-width tracking
    assign dy       = $signed({1'b0, k_reg}) - $signed({2'b00, ext_reg});
    assign dy_le0   = dy[7] || (dy == '0);
    assign dy_abs   = dy[7] ? EXT_W'(-dy) : dy[EXT_W-1:0];
    assign dy_sq    = dy_abs * dy_abs;
    assign w_op     = dy_le0 ? {1'b0, w_reg} + 1'b1 : {1'b0, w_reg};
    assign w_sq     = (2*EXT_W+1)'(w_op * w_op);
    assign dist_sum = {1'b0, w_sq} + {2'b00, dy_sq};
    assign grow     = dy_le0 && (dist_sum <= {2'b00, rsq_reg});
    assign shrink   = !dy_le0 && (dist_sum > {2'b00, rsq_reg});

    // current row
    assign w_s      = {{(COORD_W-EXT_W){1'b0}}, w_reg};
    assign k_s      = {{(COORD_W-CNT_W){1'b0}}, k_reg};
    assign ext_s    = {{(COORD_W-EXT_W){1'b0}}, ext_reg};
    assign cur_y    = by_reg + k_s;
    assign in_grid  = !cur_y[COORD_W-1] && (cur_y < HEIGHT_C);
    assign row_addr = cur_y[ROW_AW-1:0];

    // span of the current row
    always_comb begin
        case (op_reg)
            OP_CIRCLE: begin
                span_lo = bx_reg - w_s;
                span_hi = bx_reg + w_s;
            end
            OP_SQUARE: begin
                span_lo = bx_reg;
                span_hi = bx_reg + ext_s - COORD_W'(1);
            end
            OP_TRIANGLE: begin
                span_lo = bx_reg - k_s;
                span_hi = bx_reg + k_s;
            end
            default: begin
                span_lo = bx_reg;
                span_hi = bx_reg;
            end
        endcase
    end

    assign span_empty = span_hi[COORD_W-1] || (span_lo > XMAX_C) || (span_lo > span_hi);
    assign lo_col     = span_lo[COORD_W-1] ? '0 : span_lo[COL_W-1:0];
    assign hi_col     = (span_hi > XMAX_C) ? XMAX_COL : span_hi[COL_W-1:0];
    assign span_mask  = span_empty ? '0 :
                        (({ROW_W{1'b1}} << lo_col) & ({ROW_W{1'b1}} >> (TOP_COL - hi_col)));

    // row store
    assign row_valid = in_grid && valid_reg[row_addr];
    assign old_row   = row_valid ? ram_rd_data : '0;

    fsrg_ram #(
        .WIDTH (ROW_W),
        .DEPTH (GRID_HEIGHT)
    ) u_row_ram (
        .aclk    (aclk),
        .wr_en   (cmd.wr_row),
        .wr_addr (row_addr),
        .wr_data (old_row | span_mask),
        .rd_en   (cmd.rd_row),
        .rd_addr (row_addr),
        .rd_data (ram_rd_data)
    );

    // status
    always_comb begin
        sts.op_clear   = (op_reg == OP_CLEAR);
        sts.op_circle  = (op_reg == OP_CIRCLE);
        sts.op_read    = (op_reg == OP_READ);
        sts.op_draw    = (op_reg == OP_CIRCLE) || (op_reg == OP_SQUARE) ||
                         (op_reg == OP_TRIANGLE);
        sts.count_zero = (cnt_reg == '0);
        sts.adjust     = (op_reg == OP_CIRCLE) && (grow || shrink);
        sts.in_grid    = in_grid;
        sts.last_row   = (k_reg == cnt_reg - 1'b1);
        sts.out_free   = !m_valid_reg || m_ready;
    end

    assign m_valid      = m_valid_reg;
    assign m_row_bits   = row_bits_reg;
    assign m_row_number = row_number_reg;

endmodule

// File: src/filled_shape_raster_grid.sv
// ----------------------------------------------------------------------------
// filled_shape_raster_grid
// One-bit-per-pixel raster grid with filled circle, square and triangle
// drawing, whole-grid clear, and row read-back.
//
// Input channel s_*: one command word per handshake (clear, circle, square,
// triangle, read row). Output channel m_*: one word per read command, none
// for other commands.
// A new word is taken whenever the sequencer is idle, also while an earlier
// read result still waits in the output register.
// A draw reads and rewrites each row that lands on the grid and skips each
// row off it; the row read-modify-write through the single row RAM sets the
// pace. A circle also adjusts its half-width before each row.
// Reset blanks the grid at once through per-row valid bits and empties the
// output register. If the receiver stalls, a read result holds in m_*
// and a following read waits until it is taken; draws go on regardless.
// ----------------------------------------------------------------------------
module filled_shape_raster_grid #(
    parameter int GRID_WIDTH  = fsrg_pkg::DEF_GRID_WIDTH,
    parameter int GRID_HEIGHT = fsrg_pkg::DEF_GRID_HEIGHT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [fsrg_pkg::OP_W-1:0]     s_operation,
    input  logic signed [7:0]             s_pos_x,
    input  logic signed [7:0]             s_pos_y,
    input  logic [fsrg_pkg::EXT_W-1:0]    s_extent,
    input  logic [fsrg_pkg::RROW_W-1:0]   s_read_row,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [fsrg_pkg::ROW_W-1:0]    m_row_bits,
    output logic [fsrg_pkg::RROW_W-1:0]   m_row_number
);
    import fsrg_pkg::*;

    fsrg_cmd_t cmd;
    fsrg_sts_t sts;

    fsrg_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    fsrg_datapath #(
        .GRID_WIDTH  (GRID_WIDTH),
        .GRID_HEIGHT (GRID_HEIGHT)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .sts          (sts),
        .s_operation  (s_operation),
        .s_pos_x      (s_pos_x),
        .s_pos_y      (s_pos_y),
        .s_extent     (s_extent),
        .s_read_row   (s_read_row),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_row_bits   (m_row_bits),
        .m_row_number (m_row_number)
    );

endmodule
